>>> rtl/hsvled_pkg.sv
// ----------------------------------------------------------------------------
// hsvled_pkg
// Shared types and constants for the HSV to RGB LED word converter.
// ----------------------------------------------------------------------------
package hsvled_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned GAIN_W    = 16;
    localparam int unsigned HUE_W     = 16;
    localparam int unsigned FRAC_W    = 9;   // saturation, value, chroma, x, m
    localparam int unsigned CHAN_W    = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_GAIN  = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd256;
    localparam logic [FRAC_W-1:0] FRAC_ONE   = 9'd256;
    localparam logic [9:0]        HUE_SECTOR = 10'd960;

    // Hue sectors of 60 degrees each.
    localparam logic [2:0] SECT_RED_YEL   = 3'd0;
    localparam logic [2:0] SECT_YEL_GRN   = 3'd1;
    localparam logic [2:0] SECT_GRN_CYN   = 3'd2;
    localparam logic [2:0] SECT_CYN_BLU   = 3'd3;
    localparam logic [2:0] SECT_BLU_MAG   = 3'd4;

    typedef struct packed {
        logic [GAIN_W-1:0] red;
        logic [GAIN_W-1:0] green;
        logic [GAIN_W-1:0] blue;
    } t_gains;

    // One beat leaving the chroma pipeline.
    typedef struct packed {
        logic              valid;
        logic [FRAC_W-1:0] red;
        logic [FRAC_W-1:0] green;
        logic [FRAC_W-1:0] blue;
        logic [FRAC_W-1:0] m;
    } t_chroma_beat;

endpackage

>>> rtl/hsvled_cfg.sv
// ----------------------------------------------------------------------------
// hsvled_cfg
// Channel gain registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module hsvled_cfg
    import hsvled_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [CFG_IDX_W-1:0] i_wr_index,
    input  logic [GAIN_W-1:0]    i_wr_data,
    output t_gains               o_gains
);

    t_gains r_gains;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.red   <= GAIN_UNITY;
            r_gains.green <= GAIN_UNITY;
            r_gains.blue  <= GAIN_UNITY;
        end else if (i_wr_en) begin
            case (i_wr_index)
                REG_RED_GAIN:   r_gains.red   <= i_wr_data;
                REG_GREEN_GAIN: r_gains.green <= i_wr_data;
                REG_BLUE_GAIN:  r_gains.blue  <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_gains = r_gains;

endmodule

>>> rtl/hsvled_chroma.sv
// ----------------------------------------------------------------------------
// hsvled_chroma
// Four-stage pipeline from hue, saturation and value to the unscaled
// red, green and blue components and the common offset m.
// ----------------------------------------------------------------------------
module hsvled_chroma
    import hsvled_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [HUE_W-1:0]  i_hue,
    input  logic [FRAC_W-1:0] i_saturation,
    input  logic [FRAC_W-1:0] i_brightness,
    output t_chroma_beat      o_beat
);

    // Stage 1: quotient of hue by one sector, clamps.
    logic              r1_valid;
    logic [6:0]        r1_q;
    logic [HUE_W-1:0]  r1_hue;
    logic [FRAC_W-1:0] r1_s;
    logic [FRAC_W-1:0] r1_v;
    logic [6:0]        n1_q;
    logic [20:0]       n1_qprod;

    // hue/960 = (hue>>6)/15; the reciprocal 1093/2^14 is exact below 1490.
    assign n1_qprod = {1'b0, i_hue[15:6]} * 21'd1093;
    assign n1_q     = n1_qprod[20:14];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_q   <= n1_q;
        r1_hue <= i_hue;
        r1_s   <= (i_saturation > FRAC_ONE) ? FRAC_ONE : i_saturation;
        r1_v   <= (i_brightness > FRAC_ONE) ? FRAC_ONE : i_brightness;
    end

    // Stage 2: sector, position in sector, chroma.
    logic              r2_valid;
    logic [2:0]        r2_sector;
    logic [9:0]        r2_f;
    logic [FRAC_W-1:0] r2_c;
    logic [FRAC_W-1:0] r2_v;
    logic [12:0]       n2_turns_prod;
    logic [4:0]        n2_turns;
    logic [7:0]        n2_sector_w;
    logic [16:0]       n2_qbase;
    logic [16:0]       n2_f_w;
    logic [17:0]       n2_vs;

    // The sector index wraps every full turn: q mod 6, with q/6 as (q*43)>>8.
    assign n2_turns_prod = {6'd0, r1_q} * 13'd43;
    assign n2_turns      = n2_turns_prod[12:8];
    assign n2_sector_w   = {1'b0, r1_q} - ({3'd0, n2_turns} * 8'd6);
    assign n2_qbase      = {10'd0, r1_q} * {7'd0, HUE_SECTOR};
    assign n2_f_w        = {1'b0, r1_hue} - n2_qbase;
    assign n2_vs         = {9'd0, r1_v} * {9'd0, r1_s};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_sector <= n2_sector_w[2:0];
        r2_f      <= n2_f_w[9:0];
        r2_c      <= n2_vs[16:8];
        r2_v      <= r1_v;
    end

    // Stage 3: chroma times the rising or falling ramp.
    logic              r3_valid;
    logic [17:0]       r3_prod;
    logic [FRAC_W-1:0] r3_c;
    logic [FRAC_W-1:0] r3_m;
    logic [2:0]        r3_sector;
    logic [9:0]        n3_ramp;
    logic [18:0]       n3_prod;

    assign n3_ramp = r2_sector[0] ? (HUE_SECTOR - r2_f) : r2_f;
    assign n3_prod = {10'd0, r2_c} * {9'd0, n3_ramp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_prod   <= n3_prod[17:0];
        r3_c      <= r2_c;
        r3_m      <= r2_v - r2_c;
        r3_sector <= r2_sector;
    end

    // Stage 4: x = prod/960 as (prod>>6)/15, then route by sector.
    t_chroma_beat      r4_beat;
    logic [28:0]       n4_xprod;
    logic [FRAC_W-1:0] n4_x;
    logic [FRAC_W-1:0] n4_r;
    logic [FRAC_W-1:0] n4_g;
    logic [FRAC_W-1:0] n4_b;

    // 4370/2^16 is exact for every product up to 256*960.
    assign n4_xprod = {17'd0, r3_prod[17:6]} * 29'd4370;
    assign n4_x     = n4_xprod[24:16];

    always_comb begin
        case (r3_sector)
            SECT_RED_YEL: begin
                n4_r = r3_c; n4_g = n4_x; n4_b = '0;
            end
            SECT_YEL_GRN: begin
                n4_r = n4_x; n4_g = r3_c; n4_b = '0;
            end
            SECT_GRN_CYN: begin
                n4_r = '0; n4_g = r3_c; n4_b = n4_x;
            end
            SECT_CYN_BLU: begin
                n4_r = '0; n4_g = n4_x; n4_b = r3_c;
            end
            SECT_BLU_MAG: begin
                n4_r = n4_x; n4_g = '0; n4_b = r3_c;
            end
            default: begin
                n4_r = r3_c; n4_g = '0; n4_b = n4_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_beat.valid <= 1'b0;
        end else begin
            r4_beat.valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_beat.red   <= n4_r;
        r4_beat.green <= n4_g;
        r4_beat.blue  <= n4_b;
        r4_beat.m     <= r3_m;
    end

    assign o_beat = r4_beat;

endmodule

>>> rtl/hsvled_chan.sv
// ----------------------------------------------------------------------------
// hsvled_chan
// Two-stage channel finish: gain, add offset, scale to 255 and saturate.
// ----------------------------------------------------------------------------
module hsvled_chan
    import hsvled_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [FRAC_W-1:0] i_chan,
    input  logic [FRAC_W-1:0] i_m,
    input  logic [GAIN_W-1:0] i_gain,
    output logic              o_valid,
    output logic [CHAN_W-1:0] o_level
);

    logic              r_valid1;
    logic [15:0]       r_gained;
    logic [FRAC_W-1:0] r_m;
    logic [24:0]       n_gprod;

    assign n_gprod = {16'd0, i_chan} * {9'd0, i_gain};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
        end
    end

    // A 9-bit channel of at most 256 keeps the gained value within 16 bits.
    always_ff @(posedge i_clk) begin
        r_gained <= n_gprod[23:8];
        r_m      <= i_m;
    end

    logic              r_valid2;
    logic [CHAN_W-1:0] r_level;
    logic [16:0]       n_sum;
    logic [24:0]       n_scaled;
    logic [16:0]       n_val;

    assign n_sum    = {1'b0, r_gained} + {8'd0, r_m};
    assign n_scaled = {n_sum, 8'd0} - {8'd0, n_sum};
    assign n_val    = n_scaled[24:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
        end else begin
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_level <= (n_val > 17'd255) ? 8'd255 : n_val[7:0];
    end

    assign o_valid = r_valid2;
    assign o_level = r_level;

endmodule

>>> rtl/hsv_to_rgb_led_word_core.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_led_word_core
// HSV to 8-bit RGB with per-channel gain and a packed green-red-blue word.
//
//   Channel   Direction  Handshake                 Beat
//   input     in         i_start & !o_busy         hue, saturation, brightness
//   result    out        o_valid (one cycle)       red, green, blue, led_word
//   config    in         i_cfg_valid & o_cfg_ready gain index and data
//
// A new color is taken every cycle; o_busy never rises.
// Each result passes through four chroma stages, then two channel stages.
// Reset clears the pipeline valid bits and sets all gains to unity.
// The receiver cannot stall, so results never wait.
// ----------------------------------------------------------------------------
module hsv_to_rgb_led_word_core
    import hsvled_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [HUE_W-1:0]     i_hue,
    input  logic [FRAC_W-1:0]    i_saturation,
    input  logic [FRAC_W-1:0]    i_brightness,
    output logic                 o_valid,
    output logic [CHAN_W-1:0]    o_red,
    output logic [CHAN_W-1:0]    o_green,
    output logic [CHAN_W-1:0]    o_blue,
    output logic [23:0]          o_led_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data
);

    t_gains       gains;
    t_chroma_beat chroma;
    logic         red_valid;
    logic         green_valid;
    logic         blue_valid;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    hsvled_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid & o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_gains    (gains)
    );

    hsvled_chroma u_chroma (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_start & ~o_busy),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_beat       (chroma)
    );

    hsvled_chan u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chroma.valid),
        .i_chan  (chroma.red),
        .i_m     (chroma.m),
        .i_gain  (gains.red),
        .o_valid (red_valid),
        .o_level (o_red)
    );

    hsvled_chan u_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chroma.valid),
        .i_chan  (chroma.green),
        .i_m     (chroma.m),
        .i_gain  (gains.green),
        .o_valid (green_valid),
        .o_level (o_green)
    );

    hsvled_chan u_blue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chroma.valid),
        .i_chan  (chroma.blue),
        .i_m     (chroma.m),
        .i_gain  (gains.blue),
        .o_valid (blue_valid),
        .o_level (o_blue)
    );

    // The three channel pipelines run in lockstep.
    assign o_valid    = red_valid & green_valid & blue_valid;
    assign o_led_word = {o_green, o_red, o_blue};

endmodule

>>> tb/tb_hsv_to_rgb_led_word_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_led_word_core
// Self-checking bench for the HSV to RGB LED word converter. A short table of
// colors runs first at reset gains and again at extreme gains. Several gain
// settings with random colors follow. Every result beat is checked against a
// bit-exact prediction made when its color beat is accepted.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_led_word_core;
    import hsvled_pkg::*;

    localparam int unsigned HUE_TURN    = 5760;
    localparam int unsigned CHAN_MAX    = 255;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_ITEMS = 160;
    localparam int unsigned NUM_ROWS    = 12;
    // Index 3 addresses no gain register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_color;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [FRAC_W-1:0] saturation;
        logic [FRAC_W-1:0] brightness;
        logic              typed;
        t_color            color;
    } t_probe;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_start      = 1'b0;
    logic [HUE_W-1:0]     i_hue        = '0;
    logic [FRAC_W-1:0]    i_saturation = '0;
    logic [FRAC_W-1:0]    i_brightness = '0;
    logic                 i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [GAIN_W-1:0]    i_cfg_data   = '0;
    logic                 o_busy;
    logic                 o_valid;
    logic [CHAN_W-1:0]    o_red;
    logic [CHAN_W-1:0]    o_green;
    logic [CHAN_W-1:0]    o_blue;
    logic [23:0]          o_led_word;
    logic                 o_cfg_ready;

    t_gains      gain_now;
    t_color      expected_colors[$];
    t_color      oldest_color;
    t_probe      directed_rows[NUM_ROWS];
    int unsigned failures    = 0;
    int unsigned cycle_count = 0;
    bit          in_burst    = 1'b0;

    hsv_to_rgb_led_word_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_valid      (o_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_led_word   (o_led_word),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [CHAN_W-1:0] scale_channel(input int unsigned level,
                                                        input int unsigned gain,
                                                        input int unsigned m);
        int unsigned gained;
        int unsigned scaled;
        gained = (level * gain) / GAIN_UNITY;
        scaled = (CHAN_MAX * (gained + m)) / GAIN_UNITY;
        return (scaled > CHAN_MAX) ? CHAN_MAX[CHAN_W-1:0] : scaled[CHAN_W-1:0];
    endfunction

    function automatic t_color predict_color(input logic [HUE_W-1:0] hue,
                                             input logic [FRAC_W-1:0] saturation,
                                             input logic [FRAC_W-1:0] brightness);
        int unsigned h, s, v, c, m, f, x, r, g, b;
        logic [2:0]  sector;
        t_color      color;
        h = hue % HUE_TURN;
        s = (saturation > FRAC_ONE) ? FRAC_ONE : saturation;
        v = (brightness > FRAC_ONE) ? FRAC_ONE : brightness;
        c = (v * s) / FRAC_ONE;
        m = v - c;
        sector = 3'(h / HUE_SECTOR);
        f = h % HUE_SECTOR;
        // Rising edge of the hue ramp in even sectors, falling edge in odd ones.
        x = sector[0] ? (c * (HUE_SECTOR - f)) / HUE_SECTOR : (c * f) / HUE_SECTOR;
        case (sector)
            SECT_RED_YEL: begin r = c; g = x; b = 0; end
            SECT_YEL_GRN: begin r = x; g = c; b = 0; end
            SECT_GRN_CYN: begin r = 0; g = c; b = x; end
            SECT_CYN_BLU: begin r = 0; g = x; b = c; end
            SECT_BLU_MAG: begin r = x; g = 0; b = c; end
            default:      begin r = c; g = 0; b = x; end
        endcase
        color.red   = scale_channel(r, gain_now.red, m);
        color.green = scale_channel(g, gain_now.green, m);
        color.blue  = scale_channel(b, gain_now.blue, m);
        return color;
    endfunction

    function automatic void check_field(input string label, input logic [23:0] want,
                                        input logic [23:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, label, want, got);
            failures++;
        end
    endfunction

    // Results cannot be held off, so every strobed beat is checked on the spot.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected result: expected none, got %0h %0h %0h %0h",
                         $time, o_red, o_green, o_blue, o_led_word);
                failures++;
            end else begin
                oldest_color = expected_colors.pop_front();
                check_field("red", 24'(oldest_color.red), 24'(o_red));
                check_field("green", 24'(oldest_color.green), 24'(o_green));
                check_field("blue", 24'(oldest_color.blue), 24'(o_blue));
                check_field("led_word",
                            {oldest_color.green, oldest_color.red, oldest_color.blue},
                            o_led_word);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, expected_colors.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_color(input logic [HUE_W-1:0] hue,
                              input logic [FRAC_W-1:0] saturation,
                              input logic [FRAC_W-1:0] brightness,
                              input logic typed, input t_color typed_color);
        int unsigned gap;
        gap = in_burst ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_hue        <= hue;
        i_saturation <= saturation;
        i_brightness <= brightness;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        expected_colors.push_back(typed ? typed_color
                                        : predict_color(hue, saturation, brightness));
        if ($urandom_range(0, 39) == 0)
            in_burst = !in_burst;
    endtask

    // Gains change only here, with the pipeline empty.
    task automatic write_gain_reg(input logic [CFG_IDX_W-1:0] index,
                                  input logic [GAIN_W-1:0] data);
        int unsigned gap;
        gap = $urandom_range(0, 19);
        if (gap != 0) begin
            i_cfg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (index)
            REG_RED_GAIN:   gain_now.red   = data;
            REG_GREEN_GAIN: gain_now.green = data;
            REG_BLUE_GAIN:  gain_now.blue  = data;
            default: ;
        endcase
    endtask

    task automatic load_gains(input t_gains gains, input logic with_spare);
        write_gain_reg(REG_RED_GAIN, gains.red);
        write_gain_reg(REG_GREEN_GAIN, gains.green);
        if (with_spare)
            write_gain_reg(REG_SPARE, GAIN_W'($urandom_range(0, 65535)));
        write_gain_reg(REG_BLUE_GAIN, gains.blue);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_colors();
        i_start <= 1'b0;
        do @(posedge i_clk); while (expected_colors.size() != 0);
    endtask

    task automatic run_directed(input logic use_typed);
        for (int i = 0; i < NUM_ROWS; i++)
            send_color(directed_rows[i].hue, directed_rows[i].saturation,
                       directed_rows[i].brightness,
                       use_typed && directed_rows[i].typed, directed_rows[i].color);
    endtask

    function automatic logic [FRAC_W-1:0] pick_level();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 7)
            return '0;
        else if (pick < 14)
            return FRAC_ONE;
        else if (pick < 20)
            return '1;
        else if (pick < 75)
            return FRAC_W'($urandom_range(0, 256));
        return FRAC_W'($urandom_range(0, 511));
    endfunction

    function automatic logic [HUE_W-1:0] pick_hue();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return HUE_W'($urandom_range(0, HUE_TURN - 1));
        else if (pick < 85)
            return HUE_W'($urandom_range(HUE_TURN, 65535));
        // Straddle a sector boundary; below zero wraps to the top of the field.
        return HUE_W'($urandom_range(0, 6) * HUE_SECTOR - $urandom_range(0, 1));
    endfunction

    initial begin
        t_gains      gains;
        t_color      no_color;
        int unsigned pick;

        no_color = '0;
        gain_now = '{red: GAIN_UNITY, green: GAIN_UNITY, blue: GAIN_UNITY};
        directed_rows = '{
            '{16'd0,     9'd256, 9'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
            '{16'd0,     9'd0,   9'd256, 1'b1, '{8'd255, 8'd255, 8'd255}},
            '{16'd0,     9'd256, 9'd256, 1'b1, '{8'd255, 8'd0,   8'd0}},
            '{16'd960,   9'd256, 9'd256, 1'b1, '{8'd255, 8'd255, 8'd0}},
            '{16'd1920,  9'd256, 9'd256, 1'b1, '{8'd0,   8'd255, 8'd0}},
            '{16'd3840,  9'd256, 9'd256, 1'b1, '{8'd0,   8'd0,   8'd255}},
            '{16'd4800,  9'd256, 9'd256, 1'b1, '{8'd255, 8'd0,   8'd255}},
            '{16'd5760,  9'd511, 9'd511, 1'b1, '{8'd255, 8'd0,   8'd0}},
            '{16'd65535, 9'd256, 9'd256, 1'b0, '{8'd0,   8'd0,   8'd0}},
            '{16'd5759,  9'd511, 9'd300, 1'b0, '{8'd0,   8'd0,   8'd0}},
            '{16'd2880,  9'd128, 9'd200, 1'b0, '{8'd0,   8'd0,   8'd0}},
            '{16'd480,   9'd200, 9'd511, 1'b0, '{8'd0,   8'd0,   8'd0}}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset gains are unity, so the typed colors hold as written.
        run_directed(1'b1);
        drain_colors();
        load_gains('{red: 16'd0, green: 16'd65535, blue: 16'd1}, 1'b0);
        run_directed(1'b0);

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: gains = '{red: GAIN_UNITY, green: GAIN_UNITY, blue: GAIN_UNITY};
                1: gains = '{red: 16'd0, green: 16'd0, blue: 16'd0};
                2: gains = '{red: 16'hFFFF, green: 16'hFFFF, blue: 16'hFFFF};
                3: gains = '{red: 16'd255, green: 16'd257, blue: 16'd128};
                4: gains = '{red: 16'd1, green: 16'hFFFF, blue: GAIN_UNITY};
                default: begin
                    gains.red   = GAIN_W'($urandom_range(0, 65535));
                    gains.green = GAIN_W'($urandom_range(128, 400));
                    gains.blue  = GAIN_W'($urandom_range(0, 65535));
                end
            endcase
            drain_colors();
            load_gains(gains, phase == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_color(pick_hue(), pick_level(), pick_level(), 1'b0, no_color);
        end

        drain_colors();
        repeat (12) @(posedge i_clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
